>>> src/eta_pkg.sv
`default_nettype none
package eta_pkg;

  // Field and register widths.
  localparam int unsigned AttemptW = 10;
  localparam int unsigned CountW   = 8;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned SumW     = 24;
  localparam int unsigned FracW    = 8;
  localparam int unsigned MeanW    = 24;
  localparam int unsigned DvdW     = SumW + FracW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // One quotient bit per divider step.
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Register values after reset.
  localparam logic [AttemptW-1:0] MaxAttemptsRst = AttemptW'(300);
  localparam logic [CountW-1:0]   TargetRst      = CountW'(100);
  localparam logic [CountW-1:0]   MinRst         = CountW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_ATTEMPTS = 2'd0,
    CFG_TARGET       = 2'd1,
    CFG_MIN          = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_LOAD = 3'b100
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_word;
    logic div_step;
    logic load_out;
  } eta_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_done;
  } eta_status_t;

endpackage
`default_nettype wire

>>> src/eta_ctrl.sv
`default_nettype none
module eta_ctrl import eta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        attempt_valid,
  output logic             attempt_stall,
  output logic             result_valid,
  input  wire logic        result_stall,
  input  wire eta_status_t status,
  output eta_cmd_t         cmd
);

  ctrl_state_t      state, state_next;
  logic [StepW-1:0] step, step_next;
  logic             result_valid_next;

  always_comb begin
    state_next        = state;
    step_next         = step;
    cmd               = '0;
    result_valid_next = result_valid && result_stall;
    unique case (state)
      ST_IDLE: begin
        if (attempt_valid) begin
          cmd.take_word = 1'b1;
          if (status.run_done) begin
            state_next = ST_DIV;
            step_next  = '0;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + StepW'(1);
        if (step == StepW'(DivSteps - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // The output register is free when empty or being emptied now.
        if (!result_valid || !result_stall) begin
          cmd.load_out      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign attempt_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> src/eta_dpath.sv
`default_nettype none
module eta_dpath import eta_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                echo_seen,
  input  wire logic [TicksW-1:0]   echo_ticks,
  input  wire eta_cmd_t            cmd,
  output eta_status_t              status,
  output logic [MeanW-1:0]         mean_ticks,
  output logic [CountW-1:0]        good_count,
  output logic                     enough
);

  logic [AttemptW-1:0] max_attempts;
  logic [CountW-1:0]   target_successes;
  logic [CountW-1:0]   min_successes;

  logic [AttemptW-1:0] attempts_left, attempts_next;
  logic [CountW-1:0]   success_total, success_next;
  logic [SumW-1:0]     tick_sum, tick_sum_next;

  logic [DvdW-1:0]     dvd;
  logic [CountW-1:0]   divisor;
  logic [CountW-1:0]   rem;
  logic                div_enough;
  logic [CountW:0]     rem_sh;
  logic [CountW:0]     rem_diff;
  logic                q_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts     <= MaxAttemptsRst;
      target_successes <= TargetRst;
      min_successes    <= MinRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ATTEMPTS: max_attempts     <= cfg_data[AttemptW-1:0];
        CFG_TARGET:       target_successes <= cfg_data[CountW-1:0];
        CFG_MIN:          min_successes    <= cfg_data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Run totals as they stand after the offered attempt.
  always_comb begin
    attempts_next = (attempts_left != '0) ? attempts_left - AttemptW'(1) : '0;
    success_next  = success_total + CountW'(echo_seen);
    tick_sum_next = tick_sum + (echo_seen ? SumW'(echo_ticks) : '0);
  end

  assign status.run_done = (success_next >= target_successes) || (attempts_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      attempts_left <= MaxAttemptsRst;
      success_total <= '0;
      tick_sum      <= '0;
    end else if (cmd.take_word) begin
      if (status.run_done) begin
        attempts_left <= max_attempts;
        success_total <= '0;
        tick_sum      <= '0;
      end else begin
        attempts_left <= attempts_next;
        success_total <= success_next;
        tick_sum      <= tick_sum_next;
      end
    end
  end

  // Restoring divider: one quotient bit per step, the quotient shifting in
  // behind the dividend.
  always_comb begin
    rem_sh   = {rem, dvd[DvdW-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (cmd.take_word && status.run_done) begin
      dvd        <= {tick_sum_next, FracW'(0)};
      divisor    <= success_next;
      rem        <= '0;
      div_enough <= (success_next > min_successes) && (success_next != '0);
    end else if (cmd.div_step) begin
      dvd <= {dvd[DvdW-2:0], q_bit};
      rem <= q_bit ? rem_diff[CountW-1:0] : rem_sh[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_ticks <= div_enough ? dvd[MeanW-1:0] : '0;
      good_count <= divisor;
      enough     <= div_enough;
    end
  end

endmodule
`default_nettype wire

>>> src/echo_time_averager.sv
// An attempt that does not end its run produces no word.
// An attempt that ends its run yields a result word after the divide and the load.
// Throughput: one attempt per cycle within a run; a run end holds the input through
// the divide (32 divider steps, one quotient bit a cycle) and the load, longer
// while an earlier word still waits. Reset: synchronous, active high; registers 300/100/10.
`default_nettype none
module echo_time_averager import eta_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration write port.
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  // Attempt channel.
  input  wire logic                attempt_valid,
  output logic                     attempt_stall,
  input  wire logic                echo_seen,
  input  wire logic [TicksW-1:0]   echo_ticks,
  // Result channel.
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [MeanW-1:0]         mean_ticks,
  output logic [CountW-1:0]        good_count,
  output logic                     enough
);

  // The controller sequences word intake, the divide and the output load.
  // The datapath holds the configuration, the run totals, the divider and
  // the output register. A finished result may sit in the output register
  // while the next run's attempts are already being taken; the controller
  // waits before loading only if that earlier word has still not gone.

  eta_cmd_t    cmd;
  eta_status_t status;

  eta_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .attempt_valid (attempt_valid),
    .attempt_stall (attempt_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .cmd           (cmd)
  );

  eta_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .echo_seen  (echo_seen),
    .echo_ticks (echo_ticks),
    .cmd        (cmd),
    .status     (status),
    .mean_ticks (mean_ticks),
    .good_count (good_count),
    .enough     (enough)
  );

endmodule
`default_nettype wire
